// ----- rtl/mufc_pkg.sv -----
// ----------------------------------------------------------------------------
// mufc_pkg
// Shared codes, widths and constants of the meter UART frame codec.
// ----------------------------------------------------------------------------
package mufc_pkg;

	localparam int ReqW     = 2;
	localparam int AddrW    = 12;
	localparam int ValueW   = 32;
	localparam int ByteW    = 8;
	localparam int KindW    = 2;
	localparam int FrameLen = 8;
	localparam int IdxW     = $clog2(FrameLen);

	localparam int InDataW  = 56;
	localparam int OutDataW = 48;

	localparam logic [ReqW-1:0] REQ_WRITE   = 2'd0;
	localparam logic [ReqW-1:0] REQ_READ    = 2'd1;
	localparam logic [ReqW-1:0] REQ_RX_BYTE = 2'd2;
	localparam logic [ReqW-1:0] REQ_TIMEOUT = 2'd3;

	localparam logic [KindW-1:0] KIND_TX      = 2'd0;
	localparam logic [KindW-1:0] KIND_READ_OK = 2'd1;
	localparam logic [KindW-1:0] KIND_READ_ER = 2'd2;

	localparam logic [ByteW-1:0] FRAME_HEADER = 8'h7D;
	localparam logic [ByteW-1:0] CS_OFFSET    = 8'h33;
	localparam logic [3:0]       NIBBLE_MASK  = 4'hF;
	localparam logic [ByteW-1:0] READ_FLAG    = 8'h01;
	localparam logic [ByteW-1:0] READ_DATA0   = 8'h01;

	localparam logic [IdxW-1:0] IDX_LAST = IdxW'(FrameLen - 1);

	function automatic logic odd_parity(input logic [ByteW-1:0] b);
		odd_parity = ~(^b);
	endfunction

endpackage

// ----- rtl/meter_uart_frame_codec_top.sv -----
// ----------------------------------------------------------------------------
// meter_uart_frame_codec_top
// Builds meter command frames and decodes collected read replies.
// ----------------------------------------------------------------------------
// Input channel s_*: s_tuser is the request type (write, read, received
// byte, receive timeout); s_tdata holds address, write value and rx byte.
// Output channel m_*: s_tuser-like m_tuser is the result kind; a transmit
// byte carries its odd parity bit in m_tdata and m_tlast on frame byte 8.
// A write or read command yields eight transmit items, one per cycle while
// m_* is not stalled; the single frame-byte emitter behind the input
// register steps through them. A received byte or timeout yields at most
// one reply item. The first result of an item passes the input register
// and then the output register before it is on m_*. The next item is
// taken in the cycle the current one finishes, so items run back to back.
// Reset clears the input stage, the output register and the byte count;
// the collected bytes are not cleared. When the receiver holds m_tready
// low, the output register holds its item and an input item that needs
// output stalls; s_tready drops once the input stage is full.
// ----------------------------------------------------------------------------
module meter_uart_frame_codec_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata: reg_addr[11:0], write_value[43:12], rx_byte[51:44], zero pad
	input  logic [mufc_pkg::InDataW-1:0]    s_tdata,
	// s_tuser: req_type[1:0]
	input  logic [mufc_pkg::ReqW-1:0]       s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata: tx_byte[7:0], tx_parity[8], read_value[40:9], zero pad
	output logic [mufc_pkg::OutDataW-1:0]   m_tdata,
	// m_tuser: kind[1:0]
	output logic [mufc_pkg::KindW-1:0]      m_tuser,
	output logic                            m_tlast
);

	logic                              valid_s1;
	logic [mufc_pkg::ReqW-1:0]         req_s1;
	logic [mufc_pkg::AddrW-1:0]        addr_s1;
	logic [mufc_pkg::ValueW-1:0]       value_s1;
	logic [mufc_pkg::ByteW-1:0]        rxb_s1;
	logic [mufc_pkg::IdxW-1:0]         idx_q;

	logic [mufc_pkg::IdxW-1:0]         rx_count_q;
	logic [mufc_pkg::ByteW-1:0]        rx_bytes_q [mufc_pkg::FrameLen];

	logic                              out_valid_q;
	logic [mufc_pkg::KindW-1:0]        out_kind_q;
	logic [mufc_pkg::ByteW-1:0]        out_byte_q;
	logic                              out_par_q;
	logic                              out_last_q;
	logic [mufc_pkg::ValueW-1:0]       out_value_q;

	logic                              is_cmd;
	logic                              is_rx;
	logic                              needs_out;
	logic                              out_free;
	logic                              fire;
	logic                              done;
	logic                              rx_full;
	logic                              reply_ok;
	logic [mufc_pkg::ByteW-1:0]        ctrl_byte;
	logic [mufc_pkg::ByteW-1:0]        d0, d1, d2, d3;
	logic [mufc_pkg::ByteW-1:0]        sum;
	logic [mufc_pkg::ByteW-1:0]        csum;
	logic [mufc_pkg::ByteW-1:0]        frame_byte;
	logic [mufc_pkg::ValueW-1:0]       reply_value;

	assign is_cmd    = (req_s1 == mufc_pkg::REQ_WRITE) || (req_s1 == mufc_pkg::REQ_READ);
	assign is_rx     = (req_s1 == mufc_pkg::REQ_RX_BYTE);
	assign rx_full   = (rx_count_q == mufc_pkg::IDX_LAST);
	assign needs_out = !is_rx || rx_full;
	assign out_free  = !out_valid_q || m_tready;
	assign fire      = valid_s1 && (!needs_out || out_free);
	assign done      = fire && (!is_cmd || (idx_q == mufc_pkg::IDX_LAST));
	assign s_tready  = !valid_s1 || done;

	always_comb begin
		ctrl_byte = {addr_s1[11:8] & mufc_pkg::NIBBLE_MASK, 4'h0};
		if (req_s1 == mufc_pkg::REQ_READ) begin
			ctrl_byte = ctrl_byte | mufc_pkg::READ_FLAG;
			d0 = mufc_pkg::READ_DATA0;
			d1 = '0;
			d2 = '0;
			d3 = '0;
		end else begin
			d0 = value_s1[7:0];
			d1 = value_s1[15:8];
			d2 = value_s1[23:16];
			d3 = value_s1[31:24];
		end
		sum  = mufc_pkg::FRAME_HEADER + ctrl_byte + addr_s1[7:0] + d0 + d1 + d2 + d3;
		csum = ~sum + mufc_pkg::CS_OFFSET;
		case (idx_q)
			3'd0: frame_byte = mufc_pkg::FRAME_HEADER;
			3'd1: frame_byte = ctrl_byte;
			3'd2: frame_byte = addr_s1[7:0];
			3'd3: frame_byte = d0;
			3'd4: frame_byte = d1;
			3'd5: frame_byte = d2;
			3'd6: frame_byte = d3;
			default: frame_byte = csum;
		endcase
	end

	assign reply_ok    = rx_full && (rx_bytes_q[0] == mufc_pkg::FRAME_HEADER);
	assign reply_value = {rx_bytes_q[6], rx_bytes_q[5], rx_bytes_q[4], rx_bytes_q[3]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1   <= s_tuser;
			addr_s1  <= s_tdata[11:0];
			value_s1 <= s_tdata[43:12];
			rxb_s1   <= s_tdata[51:44];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (done) begin
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_count_q <= '0;
		end else if (fire) begin
			if (is_rx && !rx_full) begin
				rx_count_q <= rx_count_q + 1'b1;
			end else begin
				rx_count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_rx) begin
			rx_bytes_q[rx_count_q] <= rxb_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && needs_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && needs_out) begin
			if (is_cmd) begin
				out_kind_q  <= mufc_pkg::KIND_TX;
				out_byte_q  <= frame_byte;
				out_par_q   <= mufc_pkg::odd_parity(frame_byte);
				out_last_q  <= (idx_q == mufc_pkg::IDX_LAST);
				out_value_q <= '0;
			end else begin
				out_kind_q  <= reply_ok ? mufc_pkg::KIND_READ_OK : mufc_pkg::KIND_READ_ER;
				out_byte_q  <= '0;
				out_par_q   <= 1'b0;
				out_last_q  <= 1'b0;
				out_value_q <= reply_ok ? reply_value : '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {7'd0, out_value_q, out_par_q, out_byte_q};

endmodule

// ----- rtl/mufc_checker.sv -----
// ----------------------------------------------------------------------------
// mufc_checker
// Port-level checks of the meter UART frame codec, bound to the top level.
// ----------------------------------------------------------------------------
module mufc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [mufc_pkg::OutDataW-1:0]   m_tdata,
	input logic [mufc_pkg::KindW-1:0]      m_tuser,
	input logic                            m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output item changed while stalled");

	a_last_tx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == mufc_pkg::KIND_TX)
		else $error("frame end on a reply item");

	a_parity: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == mufc_pkg::KIND_TX |-> (^m_tdata[8:0]) == 1'b1
			&& m_tdata[40:9] == '0)
		else $error("transmit item with bad parity or stray value");

	a_reply: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != mufc_pkg::KIND_TX |-> m_tdata[8:0] == '0
			&& (m_tuser == mufc_pkg::KIND_READ_OK || m_tuser == mufc_pkg::KIND_READ_ER)
			&& (m_tuser == mufc_pkg::KIND_READ_OK || m_tdata[40:9] == '0))
		else $error("malformed reply item");

endmodule

bind meter_uart_frame_codec_top mufc_checker u_mufc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
